FILE: sv/bsws_pkg.sv
// Shared types and codes for the bounded stack with sort unit.
package bsws_pkg;

  localparam logic [2:0] CMD_PUSH  = 3'd0;
  localparam logic [2:0] CMD_POP   = 3'd1;
  localparam logic [2:0] CMD_PEEK  = 3'd2;
  localparam logic [2:0] CMD_LIST  = 3'd3;
  localparam logic [2:0] CMD_MAX   = 3'd4;
  localparam logic [2:0] CMD_EVEN  = 3'd5;
  localparam logic [2:0] CMD_ODD   = 3'd6;
  localparam logic [2:0] CMD_SORT  = 3'd7;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_EMPTY   = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_NOMATCH = 2'd3;

  localparam logic [1:0] OP_HOLD = 2'd0;
  localparam logic [1:0] OP_SHDN = 2'd1;
  localparam logic [1:0] OP_SHUP = 2'd2;
  localparam logic [1:0] OP_CMPX = 2'd3;

  typedef struct packed {
    logic [2:0]         cmd;
    logic signed [31:0] value;
  } bsws_in_t;

  typedef struct packed {
    logic signed [31:0] value_res;
    logic [1:0]         status;
    logic [3:0]         count;
    logic               last;
  } bsws_out_t;

  typedef struct packed {
    logic [1:0] op;
    logic       odd;
    logic       inject;
  } bsws_chain_t;

  typedef struct packed {
    logic [1:0] op;
    logic       odd;
    logic       own_used;
    logic       dn_used;
  } bsws_cell_ctl_t;

endpackage

FILE: sv/bsws_cell.sv
// One stack cell: holds one word and trades it with its neighbors.
module bsws_cell #(
  parameter int WORD_BITS = 32,
  parameter int IDX       = 0
) (
  input  logic                   clk,
  input  bsws_pkg::bsws_cell_ctl_t ctl,
  input  logic [WORD_BITS-1:0]   up_i,
  input  logic [WORD_BITS-1:0]   dn_i,
  output logic [WORD_BITS-1:0]   q_o
);
  import bsws_pkg::*;

  localparam logic IDX_ODD = (IDX % 2) == 1;
  localparam logic HAS_UP  = IDX > 0;

  logic [WORD_BITS-1:0] q_r;
  logic [WORD_BITS-1:0] q_nxt;
  logic                 pair_dn;
  logic                 pair_up;

  assign pair_dn = (IDX_ODD == ctl.odd) && ctl.dn_used;
  assign pair_up = HAS_UP && (IDX_ODD != ctl.odd) && ctl.own_used;

  always_comb begin
    q_nxt = q_r;
    case (ctl.op)
      OP_SHDN: q_nxt = up_i;
      OP_SHUP: q_nxt = dn_i;
      OP_CMPX: begin
        if (pair_dn && ($signed(dn_i) > $signed(q_r))) begin
          q_nxt = dn_i;
        end else if (pair_up && ($signed(up_i) < $signed(q_r))) begin
          q_nxt = up_i;
        end
      end
      default: q_nxt = q_r;
    endcase
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  assign q_o = q_r;

endmodule

FILE: sv/bsws_seq.sv
// Command sequencer: fill count, walk and sort phases, result register.
module bsws_seq #(
  parameter int DEPTH     = 8,
  parameter int WORD_BITS = 32,
  parameter int FW        = $clog2(DEPTH + 1)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  bsws_pkg::bsws_in_t    in_data,
  output logic                  out_strobe,
  output bsws_pkg::bsws_out_t   out_data,
  input  logic [WORD_BITS-1:0]  head_q,
  input  logic [WORD_BITS-1:0]  tail_q,
  output bsws_pkg::bsws_chain_t chain,
  output logic [FW-1:0]         fill_o
);
  import bsws_pkg::*;

  localparam int SW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SUMW = ((FW > SW) ? FW : SW) + 1;
  localparam logic [SW-1:0] STEP_LAST = SW'(DEPTH - 1);
  localparam logic [FW-1:0] FILL_FULL = FW'(DEPTH);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SORT = 2'd1;
  localparam logic [1:0] S_WALK = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]           state_r, state_nxt;
  logic [2:0]           cmd_r, cmd_nxt;
  logic [SW-1:0]        step_r, step_nxt;
  logic [FW-1:0]        fill_r, fill_nxt;
  logic [WORD_BITS-1:0] pend_r, pend_nxt;
  logic                 have_r, have_nxt;
  logic                 out_valid_r, out_valid_nxt;
  bsws_out_t            out_r, out_nxt;

  logic                 emit;
  logic [WORD_BITS-1:0] emit_val;
  logic [1:0]           emit_st;
  logic [FW-1:0]        emit_cnt;
  logic                 emit_last;
  logic [SUMW-1:0]      walk_pos;
  logic                 tail_used;
  logic                 match;
  logic [WORD_BITS+31:0] val_ext;
  logic [FW+3:0]        cnt_ext;

  assign busy     = state_r != S_IDLE;
  assign walk_pos = SUMW'(step_r) + SUMW'(fill_r);
  assign tail_used = walk_pos >= SUMW'(DEPTH);

  always_comb begin
    match = tail_used;
    case (cmd_r)
      CMD_EVEN: match = tail_used && !tail_q[0];
      CMD_ODD:  match = tail_used && tail_q[0];
      default:  match = tail_used;
    endcase
  end

  always_comb begin
    state_nxt    = state_r;
    cmd_nxt      = cmd_r;
    step_nxt     = step_r;
    fill_nxt     = fill_r;
    pend_nxt     = pend_r;
    have_nxt     = have_r;
    emit         = 1'b0;
    emit_val     = '0;
    emit_st      = ST_OK;
    emit_cnt     = fill_r;
    emit_last    = 1'b1;
    chain.op     = OP_HOLD;
    chain.odd    = step_r[0];
    chain.inject = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd_nxt  = in_data.cmd;
          step_nxt = '0;
          have_nxt = 1'b0;
          if (in_data.cmd == CMD_PUSH) begin
            emit = 1'b1;
            if (fill_r == FILL_FULL) begin
              emit_st = ST_FULL;
            end else begin
              chain.op     = OP_SHDN;
              chain.inject = 1'b1;
              fill_nxt     = fill_r + FW'(1);
              emit_cnt     = fill_r + FW'(1);
            end
          end else if (fill_r == '0) begin
            emit    = 1'b1;
            emit_st = ST_EMPTY;
          end else begin
            case (in_data.cmd)
              CMD_POP: begin
                chain.op = OP_SHUP;
                fill_nxt = fill_r - FW'(1);
                emit     = 1'b1;
                emit_val = head_q;
                emit_cnt = fill_r - FW'(1);
              end
              CMD_PEEK: begin
                emit     = 1'b1;
                emit_val = head_q;
              end
              CMD_LIST: begin
                if (fill_r == FILL_FULL) begin
                  emit    = 1'b1;
                  emit_st = ST_FULL;
                end else begin
                  state_nxt = S_WALK;
                end
              end
              CMD_SORT: state_nxt = S_SORT;
              default:  state_nxt = S_WALK;
            endcase
          end
        end
      end
      S_SORT: begin
        chain.op = OP_CMPX;
        if (step_r == STEP_LAST) begin
          step_nxt  = '0;
          state_nxt = S_WALK;
        end else begin
          step_nxt = step_r + SW'(1);
        end
      end
      S_WALK: begin
        chain.op = OP_SHDN;
        if (cmd_r == CMD_MAX) begin
          if (tail_used && (!have_r || ($signed(tail_q) > $signed(pend_r)))) begin
            pend_nxt = tail_q;
            have_nxt = 1'b1;
          end
        end else if (match) begin
          if (have_r) begin
            emit      = 1'b1;
            emit_val  = pend_r;
            emit_last = 1'b0;
          end
          pend_nxt = tail_q;
          have_nxt = 1'b1;
        end
        if (step_r == STEP_LAST) begin
          state_nxt = S_DONE;
        end else begin
          step_nxt = step_r + SW'(1);
        end
      end
      S_DONE: begin
        state_nxt = S_IDLE;
        emit      = 1'b1;
        if (have_r) begin
          emit_val = pend_r;
        end else begin
          emit_st = ST_NOMATCH;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    val_ext           = {{32{emit_val[WORD_BITS-1]}}, emit_val};
    cnt_ext           = {4'b0, emit_cnt};
    out_valid_nxt     = emit;
    out_nxt.value_res = val_ext[31:0];
    out_nxt.status    = emit_st;
    out_nxt.count     = cnt_ext[3:0];
    out_nxt.last      = emit_last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      have_r      <= 1'b0;
      out_valid_r <= 1'b0;
      step_r      <= '0;
      cmd_r       <= CMD_PUSH;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      have_r      <= have_nxt;
      out_valid_r <= out_valid_nxt;
      step_r      <= step_nxt;
      cmd_r       <= cmd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_r <= pend_nxt;
    out_r  <= out_nxt;
  end

  assign out_strobe = out_valid_r;
  assign out_data   = out_r;
  assign fill_o     = fill_r;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_FULL)
    else $error("fill count above depth");

  a_fill_held: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> $stable(fill_r))
    else $error("fill count moved during a multi-cycle transaction");

  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_data.last) |-> !busy)
    else $error("final result while sequencer still busy");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && (out_data.status == ST_EMPTY)) |->
      (out_data.count == 4'd0) && (out_data.value_res == 32'sd0) && out_data.last)
    else $error("empty status with data or count");

endmodule

FILE: sv/bounded_stack_with_sort_unit.sv
// Top level: bounded stack of signed words held in a chain of cells, with sort.
//
//   channel  ports                     transfer
//   input    start, busy, in_data      start && !busy
//   result   out_strobe, out_data      out_strobe, one cycle per result
//
// Push, pop and peek are handled without leaving idle; the result follows on the next cycle.
// List, max, even and odd rotate the cell chain once around; list on a full stack reports full instead.
// Sort runs DEPTH compare-exchange phases, then the list walk.
// Reset (rst_n low, synchronous) empties the stack; cell contents are not cleared.
// Results are strobed for one cycle each and cannot be held off.
module bounded_stack_with_sort_unit #(
  parameter int DEPTH     = 8,
  parameter int WORD_BITS = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  bsws_pkg::bsws_in_t  in_data,
  output logic                out_strobe,
  output bsws_pkg::bsws_out_t out_data
);
  import bsws_pkg::*;

  localparam int FW = $clog2(DEPTH + 1);

  logic [WORD_BITS-1:0]  q [DEPTH];
  logic [WORD_BITS-1:0]  head_in;
  logic [WORD_BITS+31:0] push_ext;
  logic [FW-1:0]         fill;
  logic [DEPTH-1:0]      used;
  bsws_chain_t           chain;

  assign push_ext = {{WORD_BITS{in_data.value[31]}}, in_data.value};
  assign head_in  = chain.inject ? push_ext[WORD_BITS-1:0] : q[DEPTH-1];

  bsws_seq #(
    .DEPTH     (DEPTH),
    .WORD_BITS (WORD_BITS),
    .FW        (FW)
  ) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_data    (in_data),
    .out_strobe (out_strobe),
    .out_data   (out_data),
    .head_q     (q[0]),
    .tail_q     (q[DEPTH-1]),
    .chain      (chain),
    .fill_o     (fill)
  );

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [WORD_BITS-1:0] up_w;
    logic [WORD_BITS-1:0] dn_w;
    logic                 dn_used_w;
    bsws_cell_ctl_t       ctl_w;

    assign used[i] = fill > FW'(i);

    if (i == 0) begin : g_head
      assign up_w = head_in;
    end else begin : g_mid_up
      assign up_w = q[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign dn_w      = q[i];
      assign dn_used_w = 1'b0;
    end else begin : g_mid_dn
      assign dn_w      = q[i+1];
      assign dn_used_w = used[i+1];
    end

    assign ctl_w = '{op: chain.op, odd: chain.odd, own_used: used[i], dn_used: dn_used_w};

    bsws_cell #(
      .WORD_BITS (WORD_BITS),
      .IDX       (i)
    ) u_cell (
      .clk  (clk),
      .ctl  (ctl_w),
      .up_i (up_w),
      .dn_i (dn_w),
      .q_o  (q[i])
    );
  end

endmodule
